// File: design/lprl_pkg.sv
// Shared types and constants for the longest-prefix route lookup.
package lprl_pkg;

    localparam int ADDR_W  = 32;
    localparam int INDEX_W = 4;
    localparam int IFACE_W = 4;
    localparam int MAX_ENTRIES = 1 << INDEX_W;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0]  dest;
        logic [ADDR_W-1:0]  mask;
        logic [IFACE_W-1:0] iface;
        logic               valid;
    } entry_t;

    typedef struct packed {
        logic               clear;
        logic               enable;
        logic [INDEX_W-1:0] index;
    } cmp_ctrl_t;

endpackage

// File: design/longest_prefix_route_lookup.sv
// Top level of the longest-prefix route lookup: sequencer, route table and compare unit.
// A write word is taken as soon as it is accepted and busy stays low, so a new word may follow at once.
// A lookup word raises busy for SCAN, one table read a cycle for N = min(TABLE_ENTRIES, 16)
// entries, and for FLUSH. Its result appears with done for one cycle in DONE, busy low.
// A new word can be accepted in that same cycle; no word is taken while busy.
// Reset (rst_n low, asynchronous) clears the valid bits of all routes and idles the sequencer.
module longest_prefix_route_lookup #(
    parameter int TABLE_ENTRIES = 16,
    parameter int IFACE_COUNT   = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           action,
    input  logic [lprl_pkg::INDEX_W-1:0]   entry_index,
    input  logic                           entry_valid,
    input  logic [lprl_pkg::ADDR_W-1:0]    route_dest,
    input  logic [lprl_pkg::ADDR_W-1:0]    route_mask,
    input  logic [lprl_pkg::IFACE_W-1:0]   route_iface,
    input  logic [lprl_pkg::ADDR_W-1:0]    lookup_address,
    output logic                           done,
    output logic                           found,
    output logic [lprl_pkg::INDEX_W-1:0]   best_index,
    output logic [lprl_pkg::IFACE_W-1:0]   best_iface,
    output logic [lprl_pkg::ADDR_W-1:0]    best_mask
);
    import lprl_pkg::*;

    // The entry index of a write word is four bits wide, so no more than sixteen
    // routes can ever be installed. Entries past that would never be valid and
    // could never match, so the table only holds the reachable ones.
    localparam int DEPTH = (TABLE_ENTRIES < MAX_ENTRIES) ? TABLE_ENTRIES : MAX_ENTRIES;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    // SCAN issues one table read per cycle; FLUSH lets the final read reach the
    // compare unit; DONE presents the result and is ready for the next word.
    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        FLUSH,
        DONE
    } state_t;

    state_t             state_reg,   state_next;
    logic [IDX_W-1:0]   scan_reg,    scan_next;
    logic [ADDR_W-1:0]  addr_reg,    addr_next;
    logic               cmp_en_reg,  cmp_en_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               busy_reg,    busy_next;
    logic               done_reg,    done_next;

    logic               accept;
    logic               lookup_start;
    logic               index_ok;
    logic               iface_ok;
    logic               wr_en;
    logic               rd_en;
    entry_t             rd_entry;
    cmp_ctrl_t          cmp_ctrl;

    assign accept       = start && !busy_reg;
    assign lookup_start = accept && (action == ACT_LOOKUP);

    // A write beyond the table is dropped, as is an install naming an interface
    // that does not exist. A removal within the table always takes effect.
    assign index_ok = (32'(entry_index) < DEPTH);
    assign iface_ok = (32'(route_iface) < IFACE_COUNT);
    assign wr_en    = accept && (action == ACT_WRITE) && index_ok && (!entry_valid || iface_ok);

    always_comb
    begin
        state_next   = state_reg;
        scan_next    = scan_reg;
        addr_next    = addr_reg;
        cmp_en_next  = 1'b0;
        cmp_idx_next = scan_reg;
        done_next    = 1'b0;
        rd_en        = 1'b0;
        unique case (state_reg)
            IDLE, DONE:
            begin
                state_next = IDLE;
                if (lookup_start)
                begin
                    state_next = SCAN;
                    scan_next  = '0;
                    addr_next  = lookup_address;
                end
            end
            SCAN:
            begin
                rd_en       = 1'b1;
                cmp_en_next = 1'b1;
                if (scan_reg == LAST_IDX)
                begin
                    state_next = FLUSH;
                end
                else
                begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end
            FLUSH:
            begin
                state_next = DONE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
        busy_next = (state_next == SCAN) || (state_next == FLUSH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            scan_reg   <= '0;
            cmp_en_reg <= 1'b0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            scan_reg   <= scan_next;
            cmp_en_reg <= cmp_en_next;
            busy_reg   <= busy_next;
            done_reg   <= done_next;
        end
    end

    // The lookup address and the index travelling alongside the read are payload.
    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        cmp_idx_reg <= cmp_idx_next;
    end

    lprl_table #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (entry_index[IDX_W-1:0]),
        .wr_valid (entry_valid),
        .wr_dest  (route_dest),
        .wr_mask  (route_mask),
        .wr_iface (route_iface),
        .rd_en    (rd_en),
        .rd_addr  (scan_reg),
        .rd_entry (rd_entry)
    );

    // The compare unit is cleared on the edge that takes a lookup word, then sees
    // one entry per cycle, each in the cycle after the read that fetched it.
    assign cmp_ctrl.clear  = lookup_start;
    assign cmp_ctrl.enable = cmp_en_reg;
    assign cmp_ctrl.index  = INDEX_W'(cmp_idx_reg);

    lprl_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (cmp_ctrl),
        .entry      (rd_entry),
        .address    (addr_reg),
        .found      (found),
        .best_index (best_index),
        .best_iface (best_iface),
        .best_mask  (best_mask)
    );

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// File: design/lprl_table.sv
// Route table memory with one write port, one registered read port and per-entry valid bits.
module lprl_table #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [IDX_W-1:0]               wr_addr,
    input  logic                           wr_valid,
    input  logic [lprl_pkg::ADDR_W-1:0]    wr_dest,
    input  logic [lprl_pkg::ADDR_W-1:0]    wr_mask,
    input  logic [lprl_pkg::IFACE_W-1:0]   wr_iface,
    input  logic                           rd_en,
    input  logic [IDX_W-1:0]               rd_addr,
    output lprl_pkg::entry_t               rd_entry
);
    import lprl_pkg::*;

    logic [ADDR_W-1:0]  dest_mem  [DEPTH];
    logic [ADDR_W-1:0]  mask_mem  [DEPTH];
    logic [IFACE_W-1:0] iface_mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic [ADDR_W-1:0]  rd_dest_reg;
    logic [ADDR_W-1:0]  rd_mask_reg;
    logic [IFACE_W-1:0] rd_iface_reg;
    logic               rd_valid_reg;

    // Removal only drops the valid bit; the stored fields are left alone.
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_valid)
        begin
            dest_mem[wr_addr]  <= wr_dest;
            mask_mem[wr_addr]  <= wr_mask;
            iface_mem[wr_addr] <= wr_iface;
        end
        if (rd_en)
        begin
            rd_dest_reg  <= dest_mem[rd_addr];
            rd_mask_reg  <= mask_mem[rd_addr];
            rd_iface_reg <= iface_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= wr_valid;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_entry = '{dest: rd_dest_reg, mask: rd_mask_reg, iface: rd_iface_reg,
                        valid: rd_valid_reg};

endmodule

// File: design/lprl_scan.sv
// Match-and-compare unit that keeps the best route found so far.
module lprl_scan (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lprl_pkg::cmp_ctrl_t            ctrl,
    input  lprl_pkg::entry_t               entry,
    input  logic [lprl_pkg::ADDR_W-1:0]    address,
    output logic                           found,
    output logic [lprl_pkg::INDEX_W-1:0]   best_index,
    output logic [lprl_pkg::IFACE_W-1:0]   best_iface,
    output logic [lprl_pkg::ADDR_W-1:0]    best_mask
);
    import lprl_pkg::*;

    logic               found_reg;
    logic [INDEX_W-1:0] index_reg;
    logic [IFACE_W-1:0] iface_reg;
    logic [ADDR_W-1:0]  mask_reg;
    logic               hit;
    logic               better;
    logic               take;

    // A valid entry hits when the address and its destination agree on every mask bit.
    assign hit    = entry.valid && (((address ^ entry.dest) & entry.mask) == '0);
    // Only a larger mask value displaces the current best, so ties keep the lower index.
    assign better = !found_reg || (entry.mask > mask_reg);
    assign take   = ctrl.enable && hit && better;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            index_reg <= '0;
            iface_reg <= '0;
            mask_reg  <= '0;
        end
        else if (take)
        begin
            index_reg <= ctrl.index;
            iface_reg <= entry.iface;
            mask_reg  <= entry.mask;
        end
    end

    assign found      = found_reg;
    assign best_index = index_reg;
    assign best_iface = iface_reg;
    assign best_mask  = mask_reg;

endmodule

// File: design/lprl_checker.sv
// Port-level checker for the route lookup, bound to the top level.
module lprl_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic                           action,
    input  logic                           done,
    input  logic                           found,
    input  logic [lprl_pkg::INDEX_W-1:0]   best_index,
    input  logic [lprl_pkg::IFACE_W-1:0]   best_iface,
    input  logic [lprl_pkg::ADDR_W-1:0]    best_mask
);
    import lprl_pkg::*;

    // A lookup word always makes the block busy on the following cycle.
    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_LOOKUP)) |=> busy)
        else $error("lookup word accepted without going busy");

    // A write word never makes the block busy.
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_WRITE)) |=> !busy)
        else $error("write word made the block busy");

    // The result strobe lasts one cycle and arrives once the scan has ended.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)) ##1 !done)
        else $error("result strobe malformed");

    // A miss reports all-zero route fields.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> ((best_mask == '0) && (best_index == '0) && (best_iface == '0)))
        else $error("miss reported with non-zero fields");

endmodule

bind longest_prefix_route_lookup lprl_checker u_lprl_checker (.*);
